/* rtl/core/rip_pkg.sv */
// shared types, constants and helper functions of the range image to point block
`default_nettype none

package rip_pkg;

    // field widths
    localparam int ROW_W      = 7;
    localparam int COL_W      = 12;
    localparam int RANGE_W    = 24;
    localparam int COLOUR_W   = 8;
    localparam int RGB_W      = 3 * COLOUR_W;
    localparam int HSTEP_W    = 25;
    localparam int VSTEP_W    = 24;
    localparam int LOWEST_W   = 24;
    localparam int XY_W       = 25;
    localparam int Z_W        = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 25;

    // image size defaults
    localparam int MAX_ROWS_DEF    = 128;
    localparam int MAX_COLUMNS_DEF = 4096;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HSTEP  = 2'd0,
        REG_VSTEP  = 2'd1,
        REG_LOWEST = 2'd2
    } t_reg_idx;

    localparam logic [HSTEP_W-1:0]         HSTEP_RST  = 25'd11520;
    localparam logic [VSTEP_W-1:0]         VSTEP_RST  = 24'd23040;
    localparam logic signed [LOWEST_W-1:0] LOWEST_RST = 24'sd1474560;

    // angle conversion: binary angle = floor((a * 8192 + 22) / 45)
    localparam int TURN_UNITS   = 23592960;
    localparam int ANG_SHIFT    = 13;
    localparam int ANG_BIAS     = 22;
    localparam int ANG_W        = 32;
    localparam int NUM_W        = 56;
    localparam int DIGIT_W      = 8;
    localparam int REM_W        = 6;
    localparam int STEP_W       = REM_W + DIGIT_W;
    localparam int DIV_CELLS    = NUM_W / DIGIT_W;
    localparam int DIVISOR      = 45;
    localparam int DIV45_RECIP  = 23302;
    localparam int DIV45_SHIFT  = 20;
    localparam int RECIP_W      = 15;
    localparam int STEP_PROD_W  = STEP_W + RECIP_W;

    localparam logic [ANG_W-1:0] QUARTER_TURN   = 32'h4000_0000;
    localparam logic [ANG_W-1:0] QUARTER_MINUS  = 32'h3FFF_FFFF;
    localparam logic [ANG_W-1:0] HALF_TURN      = 32'h8000_0000;

    // rotator
    localparam int CORDIC_W     = 33;
    localparam int CORDIC_STEPS = 30;
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 33'sd652032874;

    // products and scaling
    localparam int PROD_W      = 58;
    localparam int MAG_W       = 57;
    localparam int SCALE_SHIFT = 30;
    localparam int SCALED_W    = MAG_W - SCALE_SHIFT;
    localparam logic [MAG_W-1:0]    ROUND_HALF = MAG_W'(64'd1 << (SCALE_SHIFT - 1));
    localparam logic [SCALED_W-1:0] XY_LIMIT   = SCALED_W'(16777215);

    // z quotient
    localparam int QUOT_W    = 33;
    localparam int DIV_W     = 32;
    localparam int DIVISOR_W = 31;
    localparam int CMP_W     = DIVISOR_W + QUOT_W;
    localparam logic [Z_W-1:0] Z_MAX = 32'h7FFF_FFFF;
    localparam logic [Z_W-1:0] Z_MIN = 32'h8000_0000;

    localparam logic [COLOUR_W-1:0] GREY_LEVEL = 8'd26;

    // arctangent of 2^-i in 2^-32 turn
    function automatic logic [ANG_W-1:0] atan_turn(input int idx);
        logic [ANG_W-1:0] v;
        case (idx)
            0:  v = 32'd536870912;
            1:  v = 32'd316933406;
            2:  v = 32'd167458907;
            3:  v = 32'd85004756;
            4:  v = 32'd42667331;
            5:  v = 32'd21354465;
            6:  v = 32'd10679838;
            7:  v = 32'd5340245;
            8:  v = 32'd2670163;
            9:  v = 32'd1335087;
            10: v = 32'd667544;
            11: v = 32'd333772;
            12: v = 32'd166886;
            13: v = 32'd83443;
            14: v = 32'd41722;
            15: v = 32'd20861;
            16: v = 32'd10430;
            17: v = 32'd5215;
            18: v = 32'd2608;
            19: v = 32'd1304;
            20: v = 32'd652;
            21: v = 32'd326;
            22: v = 32'd163;
            23: v = 32'd81;
            24: v = 32'd41;
            25: v = 32'd20;
            26: v = 32'd10;
            27: v = 32'd5;
            28: v = 32'd3;
            29: v = 32'd1;
            default: v = '0;
        endcase
        return v;
    endfunction

    // one digit of long division by 45: returns {quotient digit, remainder}
    function automatic logic [STEP_W-1:0] div45_step(input logic [STEP_W-1:0] v);
        logic [STEP_PROD_W-1:0] p;
        logic [DIGIT_W-1:0]     q;
        logic [STEP_W-1:0]      m;
        logic [STEP_W-1:0]      r;
        p = STEP_PROD_W'(v) * STEP_PROD_W'(DIV45_RECIP);
        q = p[DIV45_SHIFT +: DIGIT_W];
        m = STEP_W'(q) * STEP_W'(DIVISOR);
        r = v - m;
        return {q, r[REM_W-1:0]};
    endfunction

    // angle conversion chain payload
    typedef struct packed {
        logic                 valid;
        logic [NUM_W-1:0]     num_az;
        logic [NUM_W-1:0]     num_el;
        logic [REM_W-1:0]     rem_az;
        logic [REM_W-1:0]     rem_el;
        logic [ANG_W-1:0]     q_az;
        logic [ANG_W-1:0]     q_el;
        logic [RANGE_W-1:0]   range;
        logic [RGB_W-1:0]     rgb;
    } t_ang;

    // rotator chain payload
    typedef struct packed {
        logic                        valid;
        logic signed [CORDIC_W-1:0]  x_az;
        logic signed [CORDIC_W-1:0]  y_az;
        logic signed [CORDIC_W-1:0]  z_az;
        logic signed [CORDIC_W-1:0]  x_el;
        logic signed [CORDIC_W-1:0]  y_el;
        logic signed [CORDIC_W-1:0]  z_el;
        logic                        flip;
        logic [RANGE_W-1:0]          range;
        logic [RGB_W-1:0]            rgb;
    } t_rot;

    // z quotient chain payload
    typedef struct packed {
        logic                    valid;
        logic [DIV_W-1:0]        rem;
        logic [DIVISOR_W-1:0]    dvs;
        logic [QUOT_W-1:0]       dvd_lo;
        logic [QUOT_W-1:0]       quot;
        logic                    ovf;
        logic                    zero;
        logic                    csat;
        logic                    neg;
        logic signed [XY_W-1:0]  px;
        logic signed [XY_W-1:0]  py;
        logic [RGB_W-1:0]        rgb;
    } t_quo;

endpackage

`default_nettype wire

/* rtl/core/rip_if.sv */
// channel interfaces: pixel input, point output and register writes
`default_nettype none

interface rip_pixel_if;
    logic                              valid;
    logic                              ready;
    logic [rip_pkg::ROW_W-1:0]         row;
    logic [rip_pkg::COL_W-1:0]         column;
    logic [rip_pkg::RANGE_W-1:0]       range;
    logic [rip_pkg::COLOUR_W-1:0]      red_in;
    logic [rip_pkg::COLOUR_W-1:0]      green_in;
    logic [rip_pkg::COLOUR_W-1:0]      blue_in;
    modport source (output valid, row, column, range, red_in, green_in, blue_in,
                    input ready);
    modport sink (input valid, row, column, range, red_in, green_in, blue_in,
                  output ready);
endinterface

interface rip_point_if;
    logic                                valid;
    logic                                ready;
    logic signed [rip_pkg::XY_W-1:0]     point_x;
    logic signed [rip_pkg::XY_W-1:0]     point_y;
    logic signed [rip_pkg::Z_W-1:0]      point_z;
    logic [rip_pkg::COLOUR_W-1:0]        red_out;
    logic [rip_pkg::COLOUR_W-1:0]        green_out;
    logic [rip_pkg::COLOUR_W-1:0]        blue_out;
    modport source (output valid, point_x, point_y, point_z, red_out, green_out, blue_out,
                    input ready);
    modport sink (input valid, point_x, point_y, point_z, red_out, green_out, blue_out,
                  output ready);
endinterface

interface rip_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [rip_pkg::CFG_IDX_W-1:0]     index;
    logic [rip_pkg::CFG_DATA_W-1:0]    data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/core/rip_div45_cell.sv */
// one byte digit of the long division by 45 for both angles
`default_nettype none

module rip_div45_cell (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_adv,
    input  wire rip_pkg::t_ang i_ang,
    output rip_pkg::t_ang      o_ang
);

    rip_pkg::t_ang                  n_ang;
    rip_pkg::t_ang                  r_ang;
    logic [rip_pkg::STEP_W-1:0]     w_az;
    logic [rip_pkg::STEP_W-1:0]     w_el;

    assign w_az = rip_pkg::div45_step({i_ang.rem_az,
                                       i_ang.num_az[rip_pkg::NUM_W-1 -: rip_pkg::DIGIT_W]});
    assign w_el = rip_pkg::div45_step({i_ang.rem_el,
                                       i_ang.num_el[rip_pkg::NUM_W-1 -: rip_pkg::DIGIT_W]});

    always_comb begin
        n_ang        = i_ang;
        n_ang.num_az = i_ang.num_az << rip_pkg::DIGIT_W;
        n_ang.num_el = i_ang.num_el << rip_pkg::DIGIT_W;
        n_ang.rem_az = w_az[rip_pkg::REM_W-1:0];
        n_ang.rem_el = w_el[rip_pkg::REM_W-1:0];
        n_ang.q_az   = {i_ang.q_az[rip_pkg::ANG_W-rip_pkg::DIGIT_W-1:0],
                        w_az[rip_pkg::STEP_W-1:rip_pkg::REM_W]};
        n_ang.q_el   = {i_ang.q_el[rip_pkg::ANG_W-rip_pkg::DIGIT_W-1:0],
                        w_el[rip_pkg::STEP_W-1:rip_pkg::REM_W]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ang.valid <= 1'b0;
        end else if (i_adv) begin
            r_ang <= n_ang;
        end
    end

    assign o_ang = r_ang;

endmodule

`default_nettype wire

/* rtl/core/rip_cordic_cell.sv */
// one rotation step for the azimuth and elevation rotators
`default_nettype none

module rip_cordic_cell #(
    parameter int STEP = 0
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_adv,
    input  wire rip_pkg::t_rot i_rot,
    output rip_pkg::t_rot      o_rot
);

    localparam logic signed [rip_pkg::CORDIC_W-1:0] ATAN =
        rip_pkg::CORDIC_W'(rip_pkg::atan_turn(STEP));

    rip_pkg::t_rot                          n_rot;
    rip_pkg::t_rot                          r_rot;
    logic signed [rip_pkg::CORDIC_W-1:0]    w_xa, w_ya, w_za, w_xe, w_ye, w_ze;
    logic signed [rip_pkg::CORDIC_W-1:0]    w_dxa, w_dya, w_dxe, w_dye;

    assign w_xa  = i_rot.x_az;
    assign w_ya  = i_rot.y_az;
    assign w_za  = i_rot.z_az;
    assign w_xe  = i_rot.x_el;
    assign w_ye  = i_rot.y_el;
    assign w_ze  = i_rot.z_el;
    assign w_dxa = w_ya >>> STEP;
    assign w_dya = w_xa >>> STEP;
    assign w_dxe = w_ye >>> STEP;
    assign w_dye = w_xe >>> STEP;

    always_comb begin
        n_rot = i_rot;
        // rotate towards zero residual angle
        if (!w_za[rip_pkg::CORDIC_W-1]) begin
            n_rot.x_az = w_xa - w_dxa;
            n_rot.y_az = w_ya + w_dya;
            n_rot.z_az = w_za - ATAN;
        end else begin
            n_rot.x_az = w_xa + w_dxa;
            n_rot.y_az = w_ya - w_dya;
            n_rot.z_az = w_za + ATAN;
        end
        if (!w_ze[rip_pkg::CORDIC_W-1]) begin
            n_rot.x_el = w_xe - w_dxe;
            n_rot.y_el = w_ye + w_dye;
            n_rot.z_el = w_ze - ATAN;
        end else begin
            n_rot.x_el = w_xe + w_dxe;
            n_rot.y_el = w_ye - w_dye;
            n_rot.z_el = w_ze + ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot.valid <= 1'b0;
        end else if (i_adv) begin
            r_rot <= n_rot;
        end
    end

    assign o_rot = r_rot;

endmodule

`default_nettype wire

/* rtl/core/rip_zdiv_cell.sv */
// one restoring division step of the height quotient
`default_nettype none

module rip_zdiv_cell (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_adv,
    input  wire rip_pkg::t_quo i_quo,
    output rip_pkg::t_quo      o_quo
);

    rip_pkg::t_quo                n_quo;
    rip_pkg::t_quo                r_quo;
    logic [rip_pkg::DIV_W-1:0]    w_trial;
    logic [rip_pkg::DIV_W-1:0]    w_dvs;
    logic                         w_ge;

    assign w_trial = {i_quo.rem[rip_pkg::DIV_W-2:0], i_quo.dvd_lo[rip_pkg::QUOT_W-1]};
    assign w_dvs   = {1'b0, i_quo.dvs};
    assign w_ge    = (w_trial >= w_dvs);

    always_comb begin
        n_quo        = i_quo;
        n_quo.rem    = w_ge ? (w_trial - w_dvs) : w_trial;
        n_quo.dvd_lo = i_quo.dvd_lo << 1;
        n_quo.quot   = {i_quo.quot[rip_pkg::QUOT_W-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quo.valid <= 1'b0;
        end else if (i_adv) begin
            r_quo <= n_quo;
        end
    end

    assign o_quo = r_quo;

endmodule

`default_nettype wire

/* rtl/core/range_image_to_point.sv */
// range image pixel to 3-d point: angle conversion, rotators, scaling and height quotient
// throughput one pixel per cycle; the whole pipeline holds while the output waits
// pixels with zero range or outside the image are taken but give no result
// synchronous active-low reset clears all valid bits and loads the default angles
`default_nettype none

module range_image_to_point #(
    parameter int MAX_ROWS    = rip_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLUMNS = rip_pkg::MAX_COLUMNS_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    rip_pixel_if.sink    i_pix,
    rip_cfg_if.sink      i_cfg,
    rip_point_if.source  o_pt
);

    // ---------------------------------------------------------------- config
    logic [rip_pkg::HSTEP_W-1:0]          r_hstep;
    logic [rip_pkg::VSTEP_W-1:0]          r_vstep;
    logic signed [rip_pkg::LOWEST_W-1:0]  r_lowest;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hstep  <= rip_pkg::HSTEP_RST;
            r_vstep  <= rip_pkg::VSTEP_RST;
            r_lowest <= rip_pkg::LOWEST_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                rip_pkg::REG_HSTEP:  r_hstep  <= i_cfg.data[rip_pkg::HSTEP_W-1:0];
                rip_pkg::REG_VSTEP:  r_vstep  <= i_cfg.data[rip_pkg::VSTEP_W-1:0];
                rip_pkg::REG_LOWEST: r_lowest <= signed'(i_cfg.data[rip_pkg::LOWEST_W-1:0]);
                default: ;  // unknown index, write dropped
            endcase
        end
    end

    // ---------------------------------------------------------- flow control
    // single advance for the whole pipeline, output register parts the sides
    logic r_out_valid;
    logic w_adv;

    assign w_adv       = !r_out_valid || o_pt.ready;
    assign i_pix.ready = w_adv;

    // ------------------------------------------------- stage 0: angle numerators
    localparam int AZ_PROD_W = rip_pkg::COL_W + rip_pkg::HSTEP_W;
    localparam int EL_PROD_W = rip_pkg::ROW_W + rip_pkg::VSTEP_W;
    localparam int EL_SUM_W  = EL_PROD_W + 4;
    localparam int EL_HI_W   = EL_PROD_W + 2;

    logic                          w_keep;
    logic                          w_black;
    logic [AZ_PROD_W-1:0]          w_az_prod;
    logic [EL_PROD_W-1:0]          w_el_prod;
    logic signed [EL_SUM_W-1:0]    w_el_sum;
    logic [rip_pkg::RGB_W-1:0]     w_rgb;
    rip_pkg::t_ang                 n_s0;
    rip_pkg::t_ang                 r_s0;

    assign w_keep = (i_pix.range != '0)
                 && (32'(i_pix.row) < 32'(MAX_ROWS))
                 && (32'(i_pix.column) < 32'(MAX_COLUMNS));

    // black pixel turns grey
    assign w_black = (i_pix.red_in == '0) && (i_pix.green_in == '0) && (i_pix.blue_in == '0);
    assign w_rgb   = w_black ? {3{rip_pkg::GREY_LEVEL}}
                             : {i_pix.red_in, i_pix.green_in, i_pix.blue_in};

    assign w_az_prod = AZ_PROD_W'(i_pix.column) * AZ_PROD_W'(r_hstep);
    assign w_el_prod = EL_PROD_W'(i_pix.row) * EL_PROD_W'(r_vstep);
    // a full turn is added so the elevation numerator never goes negative
    assign w_el_sum  = EL_SUM_W'(signed'({1'b0, w_el_prod})) - EL_SUM_W'(r_lowest)
                     + EL_SUM_W'(rip_pkg::TURN_UNITS);

    always_comb begin
        n_s0        = '0;
        n_s0.valid  = i_pix.valid && w_keep;
        n_s0.num_az = rip_pkg::NUM_W'({w_az_prod,
                                       rip_pkg::ANG_SHIFT'(rip_pkg::ANG_BIAS)});
        n_s0.num_el = rip_pkg::NUM_W'({w_el_sum[EL_HI_W-1:0],
                                       rip_pkg::ANG_SHIFT'(rip_pkg::ANG_BIAS)});
        n_s0.range  = i_pix.range;
        n_s0.rgb    = w_rgb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0.valid <= 1'b0;
        end else if (w_adv) begin
            r_s0 <= n_s0;
        end
    end

    // ------------------------------------------ division by 45, one byte a cell
    rip_pkg::t_ang w_ang [rip_pkg::DIV_CELLS+1];

    assign w_ang[0] = r_s0;

    for (genvar g = 0; g < rip_pkg::DIV_CELLS; g++) begin : g_div
        rip_div45_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_ang   (w_ang[g]),
            .o_ang   (w_ang[g+1])
        );
    end

    // ------------------------------------------------------- fold into half turn
    rip_pkg::t_ang                  w_ang_end;
    logic [rip_pkg::ANG_W-1:0]      w_ta_chk;
    logic [rip_pkg::ANG_W-1:0]      w_te_chk;
    logic [rip_pkg::ANG_W-1:0]      w_ta;
    logic [rip_pkg::ANG_W-1:0]      w_te;
    logic                           w_flip;
    rip_pkg::t_rot                  n_fold;
    rip_pkg::t_rot                  r_fold;

    assign w_ang_end = w_ang[rip_pkg::DIV_CELLS];
    // azimuth to [-90, 90) with the half turn noted, elevation to (-90, 90]
    assign w_ta_chk  = w_ang_end.q_az + rip_pkg::QUARTER_TURN;
    assign w_flip    = w_ta_chk[rip_pkg::ANG_W-1];
    assign w_ta      = w_flip ? (w_ang_end.q_az ^ rip_pkg::HALF_TURN) : w_ang_end.q_az;
    assign w_te_chk  = w_ang_end.q_el + rip_pkg::QUARTER_MINUS;
    assign w_te      = w_te_chk[rip_pkg::ANG_W-1] ? (w_ang_end.q_el ^ rip_pkg::HALF_TURN)
                                                  : w_ang_end.q_el;

    always_comb begin
        n_fold       = '0;
        n_fold.valid = w_ang_end.valid;
        n_fold.x_az  = rip_pkg::CORDIC_GAIN;
        n_fold.y_az  = '0;
        n_fold.z_az  = rip_pkg::CORDIC_W'(signed'(w_ta));
        n_fold.x_el  = rip_pkg::CORDIC_GAIN;
        n_fold.y_el  = '0;
        n_fold.z_el  = rip_pkg::CORDIC_W'(signed'(w_te));
        n_fold.flip  = w_flip;
        n_fold.range = w_ang_end.range;
        n_fold.rgb   = w_ang_end.rgb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fold.valid <= 1'b0;
        end else if (w_adv) begin
            r_fold <= n_fold;
        end
    end

    // ------------------------------------------------- rotators, one step a cell
    rip_pkg::t_rot w_rot [rip_pkg::CORDIC_STEPS+1];

    assign w_rot[0] = r_fold;

    for (genvar g = 0; g < rip_pkg::CORDIC_STEPS; g++) begin : g_rot
        rip_cordic_cell #(
            .STEP (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_rot   (w_rot[g]),
            .o_rot   (w_rot[g+1])
        );
    end

    // --------------------------------------------- products with the range
    rip_pkg::t_rot                          w_rot_end;
    logic signed [rip_pkg::PROD_W-1:0]      w_range_s;
    logic                                   r_m_valid;
    logic signed [rip_pkg::PROD_W-1:0]      r_m_px;
    logic signed [rip_pkg::PROD_W-1:0]      r_m_py;
    logic signed [rip_pkg::PROD_W-1:0]      r_m_pz;
    logic signed [rip_pkg::CORDIC_W-1:0]    r_m_c;
    logic                                   r_m_flip;
    logic [rip_pkg::RGB_W-1:0]              r_m_rgb;

    assign w_rot_end = w_rot[rip_pkg::CORDIC_STEPS];
    assign w_range_s = rip_pkg::PROD_W'(signed'({1'b0, w_rot_end.range}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_adv) begin
            r_m_valid <= w_rot_end.valid;
            r_m_px    <= w_range_s * rip_pkg::PROD_W'(w_rot_end.x_az);
            r_m_py    <= w_range_s * rip_pkg::PROD_W'(w_rot_end.y_az);
            r_m_pz    <= w_range_s * rip_pkg::PROD_W'(w_rot_end.y_el);
            r_m_c     <= w_rot_end.x_el;
            r_m_flip  <= w_rot_end.flip;
            r_m_rgb   <= w_rot_end.rgb;
        end
    end

    // ------------------------------------------------ magnitudes and flags
    logic                               r_a_valid;
    logic [rip_pkg::MAG_W-1:0]          r_a_mx;
    logic [rip_pkg::MAG_W-1:0]          r_a_my;
    logic [rip_pkg::MAG_W-1:0]          r_a_mz;
    logic                               r_a_negx;
    logic                               r_a_negy;
    logic                               r_a_negz;
    logic                               r_a_zero;
    logic                               r_a_csat;
    logic [rip_pkg::DIVISOR_W-1:0]      r_a_dvs;
    logic                               r_a_flip;
    logic [rip_pkg::RGB_W-1:0]          r_a_rgb;

    function automatic logic [rip_pkg::MAG_W-1:0] mag_of(
        input logic signed [rip_pkg::PROD_W-1:0] p
    );
        logic signed [rip_pkg::PROD_W-1:0] n;
        n = -p;
        return p[rip_pkg::PROD_W-1] ? n[rip_pkg::MAG_W-1:0] : p[rip_pkg::MAG_W-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_adv) begin
            r_a_valid <= r_m_valid;
            r_a_mx    <= mag_of(r_m_px);
            r_a_my    <= mag_of(r_m_py);
            r_a_mz    <= mag_of(r_m_pz);
            r_a_negx  <= r_m_px[rip_pkg::PROD_W-1];
            r_a_negy  <= r_m_py[rip_pkg::PROD_W-1];
            r_a_negz  <= r_m_pz[rip_pkg::PROD_W-1];
            r_a_zero  <= (r_m_pz == '0);
            // cosine at or below zero: the height saturates
            r_a_csat  <= r_m_c[rip_pkg::CORDIC_W-1] || (r_m_c == '0);
            r_a_dvs   <= r_m_c[rip_pkg::DIVISOR_W-1:0];
            r_a_flip  <= r_m_flip;
            r_a_rgb   <= r_m_rgb;
        end
    end

    // --------------------------------- rounding of x and y, dividend for z
    function automatic logic signed [rip_pkg::XY_W-1:0] round_xy(
        input logic [rip_pkg::MAG_W-1:0] mag,
        input logic                      neg
    );
        logic [rip_pkg::MAG_W-1:0]    s;
        logic [rip_pkg::SCALED_W-1:0] q;
        logic [rip_pkg::XY_W-1:0]     m;
        s = mag + rip_pkg::ROUND_HALF;
        q = s[rip_pkg::MAG_W-1:rip_pkg::SCALE_SHIFT];
        if (q > rip_pkg::XY_LIMIT) begin
            q = rip_pkg::XY_LIMIT;
        end
        m = q[rip_pkg::XY_W-1:0];
        return neg ? signed'(-m) : signed'(m);
    endfunction

    logic [rip_pkg::MAG_W-1:0]    w_dvd;
    logic                         w_ovf;
    rip_pkg::t_quo                n_q0;
    rip_pkg::t_quo                r_q0;

    // rounded quotient: (|r*s| + c/2) / c
    assign w_dvd = r_a_mz + rip_pkg::MAG_W'(r_a_dvs >> 1);
    // quotient beyond its 33 bits counts as overflow
    assign w_ovf = rip_pkg::CMP_W'(w_dvd) >= {r_a_dvs, rip_pkg::QUOT_W'(0)};

    always_comb begin
        n_q0        = '0;
        n_q0.valid  = r_a_valid;
        n_q0.rem    = rip_pkg::DIV_W'(w_dvd[rip_pkg::MAG_W-1:rip_pkg::QUOT_W]);
        n_q0.dvs    = r_a_dvs;
        n_q0.dvd_lo = w_dvd[rip_pkg::QUOT_W-1:0];
        n_q0.quot   = '0;
        n_q0.ovf    = w_ovf;
        n_q0.zero   = r_a_zero;
        n_q0.csat   = r_a_csat;
        n_q0.neg    = r_a_negz;
        n_q0.px     = round_xy(r_a_mx, r_a_negx ^ r_a_flip);
        n_q0.py     = round_xy(r_a_my, r_a_negy ^ r_a_flip);
        n_q0.rgb    = r_a_rgb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q0.valid <= 1'b0;
        end else if (w_adv) begin
            r_q0 <= n_q0;
        end
    end

    // ------------------------------------- height quotient, one bit a cell
    rip_pkg::t_quo w_quo [rip_pkg::QUOT_W+1];

    assign w_quo[0] = r_q0;

    for (genvar g = 0; g < rip_pkg::QUOT_W; g++) begin : g_quo
        rip_zdiv_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_quo   (w_quo[g]),
            .o_quo   (w_quo[g+1])
        );
    end

    // ------------------------------------------ saturation and output register
    rip_pkg::t_quo                    w_quo_end;
    logic [rip_pkg::QUOT_W-1:0]       w_quot_neg;
    logic [rip_pkg::Z_W-1:0]          w_z;
    logic signed [rip_pkg::XY_W-1:0]  r_out_x;
    logic signed [rip_pkg::XY_W-1:0]  r_out_y;
    logic [rip_pkg::Z_W-1:0]          r_out_z;
    logic [rip_pkg::RGB_W-1:0]        r_out_rgb;

    assign w_quo_end  = w_quo[rip_pkg::QUOT_W];
    assign w_quot_neg = rip_pkg::QUOT_W'(0) - w_quo_end.quot;

    always_comb begin
        if (w_quo_end.zero) begin
            w_z = '0;
        end else if (w_quo_end.csat) begin
            w_z = w_quo_end.neg ? rip_pkg::Z_MIN : rip_pkg::Z_MAX;
        end else if (w_quo_end.neg) begin
            w_z = (w_quo_end.ovf || (w_quo_end.quot > rip_pkg::QUOT_W'(rip_pkg::Z_MIN)))
                ? rip_pkg::Z_MIN : w_quot_neg[rip_pkg::Z_W-1:0];
        end else begin
            w_z = (w_quo_end.ovf || (w_quo_end.quot > rip_pkg::QUOT_W'(rip_pkg::Z_MAX)))
                ? rip_pkg::Z_MAX : w_quo_end.quot[rip_pkg::Z_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_quo_end.valid;
            r_out_x     <= w_quo_end.px;
            r_out_y     <= w_quo_end.py;
            r_out_z     <= w_z;
            r_out_rgb   <= w_quo_end.rgb;
        end
    end

    assign o_pt.valid     = r_out_valid;
    assign o_pt.point_x   = r_out_x;
    assign o_pt.point_y   = r_out_y;
    assign o_pt.point_z   = signed'(r_out_z);
    assign o_pt.red_out   = r_out_rgb[3*rip_pkg::COLOUR_W-1 -: rip_pkg::COLOUR_W];
    assign o_pt.green_out = r_out_rgb[2*rip_pkg::COLOUR_W-1 -: rip_pkg::COLOUR_W];
    assign o_pt.blue_out  = r_out_rgb[rip_pkg::COLOUR_W-1:0];

endmodule

`default_nettype wire
